### src/bmp24_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmp24_pkg
// Shared types, codes and the byte-offset helper of the 24-bit BMP stream parser.
// ----------------------------------------------------------------------------
package bmp24_pkg;

    localparam int MAX_WIDTH    = 4096;
    localparam int MAX_HEIGHT   = 4096;
    localparam int HDR_LAST     = 53;
    localparam int OUT_BITS     = 79;
    localparam int OUT_BYTES    = (OUT_BITS + 7) / 8;

    typedef enum logic [1:0] {
        EV_PIXEL  = 2'd0,
        EV_HEADER = 2'd1,
        EV_ERROR  = 2'd2
    } event_kind_t;

    typedef enum logic [2:0] {
        ERR_NONE  = 3'd0,
        ERR_SIG   = 3'd1,
        ERR_INFO  = 3'd2,
        ERR_PLANE = 3'd3,
        ERR_DEPTH = 3'd4,
        ERR_COMP  = 3'd5,
        ERR_DIM   = 3'd6
    } error_code_t;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_PIXEL,
        PH_PAD,
        PH_DONE,
        PH_ERROR
    } phase_t;

    typedef struct packed {
        logic        last_pixel;
        logic [12:0] image_height;
        logic [12:0] image_width;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [23:0] pixel_index;
        error_code_t error_code;
        event_kind_t event_kind;
    } event_t;

    // Byte position inside its little-endian header field.
    function automatic logic [1:0] field_offset(input logic [5:0] idx);
        logic [5:0] rel;
        begin
            rel = 6'd0;
            if (idx < 6'd2) begin
                rel = idx;
            end else if (idx < 6'd26) begin
                rel = idx - 6'd2;
            end else if (idx < 6'd30) begin
                rel = {5'd0, idx[0]};
            end else begin
                rel = idx - 6'd30;
            end
            return rel[1:0];
        end
    endfunction

endpackage
`default_nettype wire

### src/bmp24_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmp24_front
// Byte classifier and parse state: header gathering, pixel assembly, padding.
// ----------------------------------------------------------------------------
module bmp24_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    input  wire logic [7:0]        in_byte,
    input  wire logic              in_sof,
    output logic                   in_ready,
    output logic                   ev_valid,
    output bmp24_pkg::event_t      ev_data,
    input  wire logic              ev_full
);
    import bmp24_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] acc_reg, acc_next;
    error_code_t pend_reg, pend_next;
    logic [12:0] w_reg, w_next, h_reg, h_next;
    logic        wbad_reg, wbad_next, hbad_reg, hbad_next;
    logic [11:0] col_reg, col_next;
    logic [12:0] row_reg, row_next;
    logic [23:0] base_reg, base_next;
    logic [1:0]  bip_reg, bip_next, pad_reg, pad_next;
    logic [7:0]  blue_reg, blue_next, green_reg, green_next;

    logic        take;
    phase_t      ph;
    logic [5:0]  cnt;
    error_code_t pend;
    logic [1:0]  off;
    logic [12:0] col_inc;
    logic [12:0] row_inc;
    logic [25:0] prod;

    assign in_ready = !ev_full;
    assign take     = in_valid && !ev_full;
    assign prod     = (h_reg - 13'd1) * w_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            cnt_reg   <= '0;
            pend_reg  <= ERR_NONE;
            bip_reg   <= '0;
            pad_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            bip_reg   <= bip_next;
            pad_reg   <= pad_next;
        end
        acc_reg   <= acc_next;
        w_reg     <= w_next;
        h_reg     <= h_next;
        wbad_reg  <= wbad_next;
        hbad_reg  <= hbad_next;
        col_reg   <= col_next;
        row_reg   <= row_next;
        base_reg  <= base_next;
        blue_reg  <= blue_next;
        green_reg <= green_next;
    end

    always_comb begin
        ph         = in_sof ? PH_HEADER : phase_reg;
        cnt        = in_sof ? 6'd0 : cnt_reg;
        pend       = in_sof ? ERR_NONE : pend_reg;
        off        = field_offset(cnt);
        col_inc    = {1'b0, col_reg} + 13'd1;
        row_inc    = row_reg + 13'd1;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        pend_next  = pend_reg;
        w_next     = w_reg;
        h_next     = h_reg;
        wbad_next  = wbad_reg;
        hbad_next  = hbad_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        base_next  = base_reg;
        bip_next   = bip_reg;
        pad_next   = pad_reg;
        blue_next  = blue_reg;
        green_next = green_reg;
        ev_valid   = 1'b0;
        ev_data    = '0;
        if (take) begin
            phase_next = ph;
            pend_next  = pend;
            unique case (ph)
                PH_HEADER: begin
                    if (off == 2'd0) begin
                        acc_next = {24'd0, in_byte};
                    end else begin
                        acc_next = acc_reg | ({24'd0, in_byte} << {off, 3'd0});
                    end
                    if (pend_next == ERR_NONE) begin
                        unique case (cnt)
                            6'd1:  if (acc_next != 32'h4D42) pend_next = ERR_SIG;
                            6'd17: if (acc_next != 32'd40) pend_next = ERR_INFO;
                            6'd27: if (acc_next != 32'd1) pend_next = ERR_PLANE;
                            6'd29: if (acc_next != 32'd24) pend_next = ERR_DEPTH;
                            6'd33, 6'd37: if (acc_next != 32'd0) pend_next = ERR_COMP;
                            default: ;
                        endcase
                    end
                    if (cnt == 6'd21) begin
                        w_next    = acc_next[12:0];
                        wbad_next = acc_next[31] || (acc_next > 32'(MAX_WIDTH));
                    end
                    if (cnt == 6'd25) begin
                        h_next    = acc_next[12:0];
                        hbad_next = acc_next[31] || (acc_next > 32'(MAX_HEIGHT));
                    end
                    if (cnt != 6'(HDR_LAST)) begin
                        cnt_next = cnt + 6'd1;
                    end else begin
                        cnt_next = cnt;
                        if (pend_next == ERR_NONE && (wbad_reg || hbad_reg)) begin
                            pend_next = ERR_DIM;
                        end
                        ev_valid = 1'b1;
                        if (pend_next != ERR_NONE) begin
                            phase_next         = PH_ERROR;
                            ev_data.event_kind = EV_ERROR;
                            ev_data.error_code = pend_next;
                        end else begin
                            col_next = '0;
                            row_next = '0;
                            bip_next = '0;
                            base_next = prod[23:0];
                            phase_next = (w_reg == 13'd0 || h_reg == 13'd0) ?
                                         PH_DONE : PH_PIXEL;
                            ev_data.event_kind   = EV_HEADER;
                            ev_data.image_width  = w_reg;
                            ev_data.image_height = h_reg;
                        end
                    end
                end
                PH_PIXEL: begin
                    unique case (bip_reg)
                        2'd0: begin
                            blue_next = in_byte;
                            bip_next  = 2'd1;
                        end
                        2'd1: begin
                            green_next = in_byte;
                            bip_next   = 2'd2;
                        end
                        default: begin
                            bip_next             = 2'd0;
                            ev_valid             = 1'b1;
                            ev_data.event_kind   = EV_PIXEL;
                            ev_data.pixel_index  = base_reg + {12'd0, col_reg};
                            ev_data.red          = in_byte;
                            ev_data.green        = green_reg;
                            ev_data.blue         = blue_reg;
                            ev_data.image_width  = w_reg;
                            ev_data.image_height = h_reg;
                            col_next             = col_inc[11:0];
                            if (col_inc >= w_reg) begin
                                col_next = '0;
                                row_next = row_inc;
                                if (row_inc >= h_reg) begin
                                    ev_data.last_pixel = 1'b1;
                                    phase_next         = PH_DONE;
                                end else begin
                                    base_next = base_reg - {11'd0, w_reg};
                                    pad_next  = w_reg[1:0];
                                    if (w_reg[1:0] != 2'd0) phase_next = PH_PAD;
                                end
                            end
                        end
                    endcase
                end
                PH_PAD: begin
                    pad_next = pad_reg - 2'd1;
                    if (pad_reg <= 2'd1) begin
                        pad_next   = 2'd0;
                        phase_next = PH_PIXEL;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

### src/bmp24_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmp24_fifo
// Two-entry event queue between the parser front and the output stage.
// ----------------------------------------------------------------------------
module bmp24_fifo (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire bmp24_pkg::event_t push_data,
    output logic                   full,
    input  wire logic              pop,
    output logic                   not_empty,
    output bmp24_pkg::event_t      pop_data
);
    import bmp24_pkg::*;

    event_t     mem [2];
    logic       wr_reg, rd_reg;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = mem[rd_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + 2'd1;
        if (!push && pop) count_next = count_reg - 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
            count_reg <= '0;
        end else begin
            if (push) wr_reg <= !wr_reg;
            if (pop)  rd_reg <= !rd_reg;
            count_reg <= count_next;
        end
        if (push) mem[wr_reg] <= push_data;
    end

endmodule
`default_nettype wire

### src/bmp24_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmp24_back
// Output register: drain the queue and pack events onto the master stream.
// ----------------------------------------------------------------------------
module bmp24_back (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                q_valid,
    input  wire bmp24_pkg::event_t                   q_data,
    output logic                                     q_pop,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [8*bmp24_pkg::OUT_BYTES-1:0]        m_tdata,
    output logic                                     m_tlast
);
    import bmp24_pkg::*;

    logic   vld_reg;
    event_t ev_reg;

    assign q_pop    = q_valid && (!vld_reg || m_tready);
    assign m_tvalid = vld_reg;
    assign m_tlast  = ev_reg.last_pixel;
    assign m_tdata  = {1'b0, ev_reg.image_height, ev_reg.image_width, ev_reg.blue,
                       ev_reg.green, ev_reg.red, ev_reg.pixel_index,
                       ev_reg.error_code, ev_reg.event_kind};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (q_pop) begin
            vld_reg <= 1'b1;
        end else if (m_tready) begin
            vld_reg <= 1'b0;
        end
        if (q_pop) ev_reg <= q_data;
    end

endmodule
`default_nettype wire

### src/bmp24_stream_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmp24_stream_parser
// 24-bit uncompressed BMP byte-stream parser with RGB pixel output.
// ----------------------------------------------------------------------------
// Feed the file one byte per word; tuser high marks the first byte of a file
// and restarts the parse. The 54 header bytes give one header word (width,
// height) or one error word; pixel bytes then give one RGB word per pixel
// with a row-flipped index, and tlast marks the final pixel. Row padding and
// bytes after completion or an error give no word. The block takes one byte
// per clock unless the queue is full; each byte updates the parse counters; a
// two-entry queue plus an output register keep input and output stalls apart.
module bmp24_stream_parser (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,   // [7:0] data_byte
    input  wire logic                          s_tuser,   // [0] start_of_file
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [1:0] event_kind, [4:2] error_code, [28:5] pixel_index, [36:29] red,
    // [44:37] green, [52:45] blue, [65:53] image_width, [78:66] image_height
    output logic [8*bmp24_pkg::OUT_BYTES-1:0]  m_tdata,
    output logic                               m_tlast    // last_pixel
);
    import bmp24_pkg::*;

    logic   ev_valid, q_full, q_pop, q_valid;
    event_t ev_data, q_data;

    // Front: classify each byte and advance parse state.
    bmp24_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_byte  (s_tdata),
        .in_sof   (s_tuser),
        .in_ready (s_tready),
        .ev_valid (ev_valid),
        .ev_data  (ev_data),
        .ev_full  (q_full)
    );

    // Queue: hold events while the output side stalls.
    bmp24_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (ev_valid),
        .push_data (ev_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_data)
    );

    // Back: register and pack results.
    bmp24_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !ev_valid)
        else $error("event pushed into full queue");
    a_last_is_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[1:0] == EV_PIXEL))
        else $error("tlast on non-pixel word");
    a_error_has_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1:0] == EV_ERROR) |-> (m_tdata[4:2] != ERR_NONE))
        else $error("error word without code");
    a_pop_only_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

### sim/bmp24_event_checker.sv
// ----------------------------------------------------------------------------
// bmp24_event_checker
// Watches both channels of the BMP parser, predicts each event word from the
// accepted bytes and compares it field by field with the words that come out.
// ----------------------------------------------------------------------------
module bmp24_event_checker
    import bmp24_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    input  wire logic                     s_tready,
    input  wire logic [7:0]               s_tdata,
    input  wire logic                     s_tuser,
    input  wire logic                     m_tvalid,
    input  wire logic                     m_tready,
    input  wire logic [8*OUT_BYTES-1:0]   m_tdata,
    input  wire logic                     m_tlast,
    output int                            fail_count,
    output int                            pending_events,
    output int                            pixel_events,
    output int                            header_events,
    output int                            error_events
);
    timeunit 1ns;
    timeprecision 1ps;

    event_t     expected_events[$];
    phase_t     phase;
    logic [5:0] hdr_pos;
    logic [31:0] field_acc;
    error_code_t first_err;
    logic [31:0] width_q, height_q;
    logic [31:0] col, row, row_base;
    logic [1:0] pix_byte, pad_left;
    logic [7:0] blue_q, green_q;

    function automatic logic [5:0] field_base(input logic [5:0] i);
        if (i < 2) return 6'd0;
        if (i < 14) return 6'(2 + ((i - 2) / 4) * 4);
        if (i < 26) return 6'(14 + ((i - 14) / 4) * 4);
        if (i < 30) return 6'(26 + ((i - 26) / 2) * 2);
        return 6'(30 + ((i - 30) / 4) * 4);
    endfunction

    function automatic logic dim_valid(input logic [31:0] v, input int maxv);
        return !v[31] && v <= maxv;
    endfunction

    task automatic note_error(input error_code_t code);
        if (first_err == ERR_NONE) first_err = code;
    endtask

    task automatic clear_parse();
        phase = PH_HEADER; hdr_pos = 0; field_acc = 0; first_err = ERR_NONE;
        width_q = 0; height_q = 0; col = 0; row = 0; row_base = 0;
        pix_byte = 0; pad_left = 0; blue_q = 0; green_q = 0;
    endtask

    // Advance the parse by one byte and queue the event it causes, if any.
    task automatic parse_byte(input logic [7:0] b, input logic sof);
        event_t ev;
        logic [5:0] st;
        ev = '0;
        if (sof) clear_parse();
        case (phase)
            PH_HEADER: begin
                st = field_base(hdr_pos);
                if (hdr_pos == st) field_acc = {24'd0, b};
                else field_acc = field_acc | ({24'd0, b} << (8 * (hdr_pos - st)));
                case (hdr_pos)
                    1:  if (field_acc != 32'h4D42) note_error(ERR_SIG);
                    17: if (field_acc != 40) note_error(ERR_INFO);
                    21: width_q = field_acc;
                    25: height_q = field_acc;
                    27: if (field_acc != 1) note_error(ERR_PLANE);
                    29: if (field_acc != 24) note_error(ERR_DEPTH);
                    33, 37: if (field_acc != 0) note_error(ERR_COMP);
                    default: ;
                endcase
                if (hdr_pos < HDR_LAST) begin
                    hdr_pos++;
                    return;
                end
                if (!dim_valid(width_q, MAX_WIDTH) || !dim_valid(height_q, MAX_HEIGHT))
                    note_error(ERR_DIM);
                if (first_err != ERR_NONE) begin
                    phase = PH_ERROR;
                    ev.event_kind = EV_ERROR;
                    ev.error_code = first_err;
                end else begin
                    col = 0; row = 0; pix_byte = 0;
                    if (width_q == 0 || height_q == 0) phase = PH_DONE;
                    else begin
                        phase = PH_PIXEL;
                        row_base = (height_q - 1) * width_q;
                    end
                    ev.event_kind = EV_HEADER;
                    ev.image_width = width_q[12:0];
                    ev.image_height = height_q[12:0];
                end
                expected_events.push_back(ev);
            end
            PH_PIXEL: begin
                if (pix_byte == 0) begin
                    blue_q = b; pix_byte = 1; return;
                end
                if (pix_byte == 1) begin
                    green_q = b; pix_byte = 2; return;
                end
                pix_byte = 0;
                ev.event_kind = EV_PIXEL;
                ev.pixel_index = 24'(row_base + col);
                ev.red = b; ev.green = green_q; ev.blue = blue_q;
                ev.image_width = width_q[12:0];
                ev.image_height = height_q[12:0];
                col++;
                if (col >= width_q) begin
                    col = 0;
                    row++;
                    if (row >= height_q) begin
                        ev.last_pixel = 1'b1;
                        phase = PH_DONE;
                    end else begin
                        row_base = row_base - width_q;
                        pad_left = width_q[1:0];
                        if (pad_left != 0) phase = PH_PAD;
                    end
                end
                expected_events.push_back(ev);
            end
            PH_PAD: begin
                if (pad_left > 0) pad_left--;
                if (pad_left == 0) phase = PH_PIXEL;
            end
            default: ;
        endcase
    endtask

    initial begin
        fail_count = 0; pixel_events = 0; header_events = 0; error_events = 0;
        pending_events = 0;
        clear_parse();
    end

    always @(posedge aclk) begin
        event_t got, exp_ev;
        if (!aresetn) begin
            clear_parse();
        end else begin
            // Compare the output word first: its prediction was queued earlier.
            if (m_tvalid && m_tready) begin
                got = event_t'(m_tdata[OUT_BITS-1:0]);
                got.last_pixel = m_tlast;
                if (expected_events.size() == 0) begin
                    $display("%0t: unexpected word %h", $time, m_tdata);
                    fail_count++;
                end else begin
                    exp_ev = expected_events.pop_front();
                    if (got != exp_ev || m_tdata[8*OUT_BYTES-1:OUT_BITS] != 0) begin
                        $display("%0t: expected k=%0d e=%0d i=%0d rgb=%h%h%h w=%0d h=%0d l=%0b",
                                 $time, exp_ev.event_kind, exp_ev.error_code,
                                 exp_ev.pixel_index, exp_ev.red, exp_ev.green,
                                 exp_ev.blue, exp_ev.image_width,
                                 exp_ev.image_height, exp_ev.last_pixel);
                        $display("%0t: actual   k=%0d e=%0d i=%0d rgb=%h%h%h w=%0d h=%0d l=%0b",
                                 $time, got.event_kind, got.error_code,
                                 got.pixel_index, got.red, got.green, got.blue,
                                 got.image_width, got.image_height, got.last_pixel);
                        fail_count++;
                    end
                    case (got.event_kind)
                        EV_PIXEL:  pixel_events++;
                        EV_HEADER: header_events++;
                        default:   error_events++;
                    endcase
                end
            end
            if (s_tvalid && s_tready) parse_byte(s_tdata, s_tuser);
        end
        pending_events = expected_events.size();
    end

endmodule

### sim/tb_bmp24_stream_parser.sv
// ----------------------------------------------------------------------------
// tb_bmp24_stream_parser
// Feeds BMP files of random sizes, broken headers and noise into the parser
// under random input gaps and output stalls; the checker judges each word.
// ----------------------------------------------------------------------------
module tb_bmp24_stream_parser;
    timeunit 1ns;
    timeprecision 1ps;
    import bmp24_pkg::*;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [7:0]                s_tdata = '0;
    logic                      s_tuser = 1'b0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [8*OUT_BYTES-1:0]    m_tdata;
    logic                      m_tlast;
    int                        fail_count, pending_events;
    int                        pixel_events, header_events, error_events;
    int                        bytes_sent = 0;
    int                        files_sent = 0;
    int                        burst_left = 0;
    bit                        hold_off = 1'b0;   // long receiver stall request
    bit                        stall_quiet = 1'b0;
    logic [7:0]                file_bytes[$];
    logic                      stream_done = 1'b0;

    always #1 aclk = ~aclk;

    bmp24_stream_parser i_dut (.*);

    bmp24_event_checker i_checker (.*);

    // Receiver: stall on its own pattern; hold off completely when asked.
    always @(negedge aclk) begin
        int hold_cycles;
        if (hold_off) begin
            m_tready <= 1'b0;
            for (hold_cycles = 0; hold_cycles < 400; hold_cycles++) @(negedge aclk);
            hold_off = 1'b0;
        end else if (stall_quiet) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Build one file into file_bytes. A zero kind gives a good header.
    task automatic build_file(input int w, input int h, input int broken);
        logic [31:0] hdr_w, hdr_h;
        int total;
        file_bytes = {};
        hdr_w = w; hdr_h = h;
        for (int i = 0; i < 54; i++) file_bytes.push_back($urandom_range(0, 255));
        file_bytes[0] = "B"; file_bytes[1] = "M";
        {file_bytes[17], file_bytes[16], file_bytes[15], file_bytes[14]} = 32'd40;
        {file_bytes[21], file_bytes[20], file_bytes[19], file_bytes[18]} = hdr_w;
        {file_bytes[25], file_bytes[24], file_bytes[23], file_bytes[22]} = hdr_h;
        {file_bytes[27], file_bytes[26]} = 16'd1;
        {file_bytes[29], file_bytes[28]} = 16'd24;
        for (int i = 30; i < 38; i++) file_bytes[i] = 8'd0;
        // Break one header field, and sometimes another as well.
        case (broken)
            1: file_bytes[$urandom_range(0, 1)] ^= 8'd1 << $urandom_range(0, 7);
            2: file_bytes[$urandom_range(14, 17)] ^= 8'd1 << $urandom_range(0, 7);
            3: file_bytes[$urandom_range(26, 27)] ^= 8'd1 << $urandom_range(0, 7);
            4: file_bytes[$urandom_range(28, 29)] ^= 8'd1 << $urandom_range(0, 7);
            5: file_bytes[$urandom_range(30, 37)] ^= 8'd1 << $urandom_range(0, 7);
            6: begin
                file_bytes[$urandom_range(0, 37)] ^= 8'd1 << $urandom_range(0, 7);
                file_bytes[$urandom_range(0, 37)] ^= 8'd1 << $urandom_range(0, 7);
            end
            default: ;
        endcase
        total = (broken == 0 && w > 0 && h > 0 && w <= MAX_WIDTH && h <= MAX_HEIGHT)
                ? h * (3 * w + (w & 3)) : $urandom_range(0, 8);
        for (int i = 0; i < total; i++) file_bytes.push_back($urandom_range(0, 255));
        // Trailing bytes after completion are ignored by the parser.
        repeat ($urandom_range(0, 3)) file_bytes.push_back($urandom_range(0, 255));
    endtask

    // Send one word with bursty gaps; tuser marks the first byte of a file.
    // Hold tvalid high between back-to-back words; drop it only in a gap.
    task automatic send_byte(input logic [7:0] b, input logic sof);
        if (burst_left == 0) begin
            if ($urandom_range(0, 2) == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= sof;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic send_file(input int w, input int h, input int broken);
        build_file(w, h, broken);
        foreach (file_bytes[i]) send_byte(file_bytes[i], i == 0);
        files_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_events != 0) @(negedge aclk);
    endtask

    initial begin
        int sel;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: clean small images with padding of one and three bytes.
        send_file(1, 2, 0);
        send_file(3, 2, 0);
        // Header errors in each field, then bad dimensions on both sides.
        for (int k = 1; k <= 5; k++) send_file(1, 1, k);
        send_file(-1, MAX_HEIGHT + 1, 0);
        // Largest accepted width with an empty image.
        send_file(MAX_WIDTH, 0, 0);
        // Pause the sender until every result is out.
        drain();

        // Long receiver hold-off while bytes keep coming: fill up and stall.
        hold_off = 1'b1;
        send_file(6, 3, 0);

        // A header cut short and restarted by a new file.
        build_file(2, 1, 0);
        for (int i = 0; i < 20; i++) send_byte(file_bytes[i], i == 0);
        send_file(2, 1, 0);

        while (bytes_sent < 800) begin
            sel = $urandom_range(0, 9);
            if (sel < 6) send_file($urandom_range(1, 7), $urandom_range(1, 4), 0);
            else if (sel < 8) send_file($urandom_range(0, 8), $urandom_range(0, 3),
                                        $urandom_range(1, 6));
            else if (sel < 9) send_file(($urandom_range(0, 1) != 0)
                                        ? -$urandom_range(1, 200)
                                        : MAX_WIDTH + $urandom_range(1, 4000),
                                        $urandom_range(0, 9000) - 200, 0);
            else repeat ($urandom_range(1, 10)) send_byte($urandom_range(0, 255),
                                                          $urandom_range(0, 1));
            if ($urandom_range(0, 20) == 0) begin
                s_tvalid <= 1'b0;
                stall_quiet = 1'b1;
                repeat ($urandom_range(10, 40)) @(negedge aclk);
                stall_quiet = 1'b0;
            end
        end
        s_tvalid <= 1'b0;
        stream_done = 1'b1;
    end

    initial begin
        wait (stream_done);
        while (pending_events != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        $display("Sent %0d bytes in %0d files; got %0d pixel, %0d header, %0d error words.",
                 bytes_sent, files_sent, pixel_events, header_events, error_events);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule

### filelist.f
src/bmp24_pkg.sv
src/bmp24_front.sv
src/bmp24_fifo.sv
src/bmp24_back.sv
src/bmp24_stream_parser.sv
sim/bmp24_event_checker.sv
sim/tb_bmp24_stream_parser.sv
